/* rtl/core/blf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types and constants for the blob labeling / farthest pair block.
// ----------------------------------------------------------------------------
package blf_pkg;

    localparam int CFG_W    = 9;   // widest config register
    localparam int CFG_IW   = 2;   // config register index width
    localparam int THRESH_W = 8;
    localparam int LABEL_W  = 8;
    localparam int PAIR_W   = 5;   // blob number inside the seed set, up to 31
    localparam int OUT_PAIR_W = 3;

    localparam logic [THRESH_W-1:0] THRESH_RST = 8'd20;
    localparam logic [CFG_W-1:0]    SIZE_RST   = 9'd256;

    typedef enum logic [CFG_IW-1:0] {
        CFG_THRESH = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_COLS   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_SUMMARY = 1'b0,
        KIND_LABEL   = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_SC_RD,
        ST_SC_CHK,
        ST_DQ_RD,
        ST_DQ_WAIT,
        ST_NB_RD,
        ST_NB_CHK,
        ST_PAIR,
        ST_SUM
    } t_state;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_LOAD_I,
        PS_LOAD_J,
        PS_SQ_R,
        PS_SQ_C,
        PS_CMP,
        PS_DONE
    } t_pair_st;

    typedef struct packed {
        logic              done;
        logic [PAIR_W-1:0] first;
        logic [PAIR_W-1:0] second;
    } t_pair_res;

endpackage

/* rtl/core/blf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blf_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module blf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/blf_pair.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blf_pair
// Farthest seed pair search; one shared squarer walks all pairs in order.
// ----------------------------------------------------------------------------
module blf_pair #(
    parameter int SEED_SLOTS = 4,
    parameter int RW = 8,
    parameter int CW = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [$clog2(SEED_SLOTS+1)-1:0]       i_kk,
    input  logic [SEED_SLOTS-1:0][RW+CW-1:0]      i_seeds,
    output blf_pkg::t_pair_res                    o_res
);
    import blf_pkg::*;

    localparam int KW  = $clog2(SEED_SLOTS + 1);
    localparam int SIW = $clog2(SEED_SLOTS);
    localparam int MW  = (RW > CW) ? RW : CW;
    localparam int DW  = 2 * MW + 1;

    t_pair_st r_state, n_state;
    logic [KW-1:0]   r_i, r_j;
    logic [RW-1:0]   r_ar, r_dr;
    logic [CW-1:0]   r_ac, r_dc;
    logic [DW-1:0]   r_acc, r_best;
    logic            r_found;
    logic [PAIR_W-1:0] r_a, r_b;

    logic [SIW-1:0]   sel;
    logic [RW+CW-1:0] seed;
    logic [RW-1:0]    sr;
    logic [CW-1:0]    sc;
    logic [MW-1:0]    op;
    logic [2*MW-1:0]  prod;
    logic [KW-1:0]    i_nx, j_nx;

    assign sel  = (r_state == PS_LOAD_I) ? r_i[SIW-1:0] : r_j[SIW-1:0];
    assign seed = i_seeds[sel];
    assign sr   = seed[RW+CW-1:CW];
    assign sc   = seed[CW-1:0];
    assign op   = (r_state == PS_SQ_R) ? MW'(r_dr) : MW'(r_dc);
    assign prod = op * op;
    assign i_nx = r_i + KW'(1);
    assign j_nx = r_j + KW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PS_IDLE:   if (i_start) n_state = (i_kk < KW'(2)) ? PS_DONE : PS_LOAD_I;
            PS_LOAD_I: n_state = (i_nx >= i_kk) ? PS_DONE : PS_LOAD_J;
            PS_LOAD_J: n_state = PS_SQ_R;
            PS_SQ_R:   n_state = PS_SQ_C;
            PS_SQ_C:   n_state = PS_CMP;
            PS_CMP:    n_state = (j_nx == i_kk) ? PS_LOAD_I : PS_LOAD_J;
            PS_DONE:   n_state = PS_IDLE;
            default:   n_state = PS_IDLE;
        endcase
    end

    always_comb begin
        o_res.done   = (r_state == PS_DONE);
        o_res.first  = r_a;
        o_res.second = r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_IDLE;
            r_found <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                PS_IDLE: begin
                    if (i_start) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_a     <= '0;
                        r_b     <= '0;
                    end
                end
                PS_LOAD_I: begin
                    r_ar <= sr;
                    r_ac <= sc;
                    r_j  <= i_nx;
                end
                PS_LOAD_J: begin
                    r_dr <= (r_ar > sr) ? r_ar - sr : sr - r_ar;
                    r_dc <= (r_ac > sc) ? r_ac - sc : sc - r_ac;
                end
                PS_SQ_R: r_acc <= DW'(prod);
                PS_SQ_C: r_acc <= r_acc + DW'(prod);
                PS_CMP: begin
                    if (!r_found || r_acc > r_best) begin
                        r_found <= 1'b1;
                        r_best  <= r_acc;
                        r_a     <= PAIR_W'(r_i) + PAIR_W'(1);
                        r_b     <= PAIR_W'(r_j) + PAIR_W'(1);
                    end
                    if (j_nx == i_kk) begin
                        r_i <= i_nx;
                    end
                    r_j <= j_nx;
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/core/blob_label_farthest_pair_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_label_farthest_pair_top
// 8-connected blob labeling of a thresholded frame with farthest seed pair.
// ----------------------------------------------------------------------------
// Pixels load one per cycle (opcode load) into a dark bit map while the
// input is not stalled; a word with frame_last set starts labeling.
// Labeling first clears the whole label memory (MAX_ROWS*MAX_COLS rounded
// up to a power of two entries), then scans the frame pixel by pixel, a read
// and then a check; each new blob is flood filled breadth first through a
// queue memory, each dequeue followed by nine neighbor probes of the
// dequeued pixel, a probe off the frame edge being skipped without a check,
// all on one read port of the dark and label memories. The farthest pair
// search among the first SEED_SLOTS seeds then walks each pair through
// load, row square, column square and compare on one shared squarer, after
// which one summary word is emitted. A read word returns one pixel label.
// The input stalls while any of this is running or while a result word
// waits, and in the cycle after reset or after a config write.
// Memories hold no reset: a flag returns labels of zero before the first
// labeling pass.
// ----------------------------------------------------------------------------
module blob_label_farthest_pair_top #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int SEED_SLOTS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config
    input  logic                         i_cfg_we,
    input  logic [blf_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [blf_pkg::CFG_W-1:0]    i_cfg_data,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [7:0]                   i_pixel_value,
    input  logic                         i_frame_last,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_kind,
    output logic [7:0]                   o_blob_label,
    output logic                         o_in_far_pair,
    output logic [7:0]                   o_blob_total,
    output logic [2:0]                   o_pair_first,
    output logic [2:0]                   o_pair_second,
    output logic                         o_label_overflow,
    output logic                         o_read_last
);
    import blf_pkg::*;

    localparam int AW   = $clog2(MAX_ROWS * MAX_COLS);
    localparam int NPIX = 2 ** AW;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int ERW  = $clog2(MAX_ROWS + 1);
    localparam int ECW  = $clog2(MAX_COLS + 1);
    localparam int NW   = AW + 1;
    localparam int QW   = AW + RW + CW;
    localparam int KW   = $clog2(SEED_SLOTS + 1);
    localparam int SIW  = $clog2(SEED_SLOTS);
    localparam int CNTW = LABEL_W + 1;   // saturates at 256: overflow

    // config
    logic [THRESH_W-1:0] r_thresh;
    logic [CFG_W-1:0]    r_rows, r_cols;
    logic                r_settle;
    logic [ERW-1:0]      eff_rows;
    logic [ECW-1:0]      eff_cols;
    logic [NW-1:0]       r_n;

    t_state r_state, n_state;

    // pointers and scan
    logic [NW-1:0]  r_lp, r_rp, rp_eff;
    logic [AW-1:0]  r_clr, r_p;
    logic [RW-1:0]  r_sr, last_row;
    logic [CW-1:0]  r_sc, last_col;
    logic [CNTW-1:0] r_count;
    logic [LABEL_W-1:0] r_lab, lab_new;
    logic           r_labeled, r_rd_last;
    logic           scan_end, adv_scan;

    // flood fill
    logic [NW-1:0]  r_head, r_tail;
    logic [AW-1:0]  r_q;
    logic [RW-1:0]  r_qr;
    logic [CW-1:0]  r_qc;
    logic [1:0]     r_nr, r_nc;
    logic [AW-1:0]  nb_addr, nb_base;
    logic [RW-1:0]  nb_r;
    logic [CW-1:0]  nb_c;
    logic           nb_ok, nb_end, nb_step, hit;

    // seeds and pair
    logic [SEED_SLOTS-1:0][RW+CW-1:0] r_seed;
    logic [KW-1:0]  kk;
    t_pair_res      pair_res;
    logic [PAIR_W-1:0] r_far_a, r_far_b;

    // memory ports
    logic              dark_we, dark_wdata, dark_q;
    logic [AW-1:0]     rd_addr;
    logic              label_we;
    logic [AW-1:0]     label_waddr;
    logic [LABEL_W-1:0] label_wdata, label_q;
    logic              q_we;
    logic [QW-1:0]     q_wdata, q_rdata;

    logic in_acc;
    logic [LABEL_W-1:0] rd_lab;

    // effective frame size
    always_comb begin
        if (r_rows == '0)                 eff_rows = ERW'(1);
        else if (int'(r_rows) > MAX_ROWS) eff_rows = ERW'(MAX_ROWS);
        else                              eff_rows = ERW'(r_rows);
        if (r_cols == '0)                 eff_cols = ECW'(1);
        else if (int'(r_cols) > MAX_COLS) eff_cols = ECW'(MAX_COLS);
        else                              eff_cols = ECW'(r_cols);
    end

    assign last_row = RW'(eff_rows - ERW'(1));
    assign last_col = CW'(eff_cols - ECW'(1));
    assign in_acc   = i_in_valid && !o_in_stall;
    assign rp_eff   = (r_rp >= r_n) ? '0 : r_rp;
    assign scan_end = (NW'(r_p) == r_n - NW'(1));
    assign hit      = dark_q && (label_q == '0);
    assign lab_new  = (r_count >= CNTW'(255)) ? LABEL_W'(255) : LABEL_W'(r_count + CNTW'(1));
    assign kk       = (r_count < CNTW'(SEED_SLOTS)) ? KW'(r_count) : KW'(SEED_SLOTS);

    // neighbor of the dequeued pixel selected by r_nr / r_nc (0,1,2 = -1,0,+1)
    always_comb begin
        nb_ok = 1'b1;
        if (r_nr == 2'd0 && r_qr == '0)       nb_ok = 1'b0;
        if (r_nr == 2'd2 && r_qr == last_row) nb_ok = 1'b0;
        if (r_nc == 2'd0 && r_qc == '0)       nb_ok = 1'b0;
        if (r_nc == 2'd2 && r_qc == last_col) nb_ok = 1'b0;
        case (r_nr)
            2'd0:    nb_base = r_q - AW'(eff_cols);
            2'd2:    nb_base = r_q + AW'(eff_cols);
            default: nb_base = r_q;
        endcase
        case (r_nc)
            2'd0:    nb_addr = nb_base - AW'(1);
            2'd2:    nb_addr = nb_base + AW'(1);
            default: nb_addr = nb_base;
        endcase
        nb_r = r_qr + RW'(r_nr) - RW'(1);
        nb_c = r_qc + CW'(r_nc) - CW'(1);
    end

    assign nb_end   = (r_nr == 2'd2) && (r_nc == 2'd2);
    assign nb_step  = (r_state == ST_NB_RD && !nb_ok) || (r_state == ST_NB_CHK);
    assign adv_scan = (r_state == ST_SC_CHK && !hit) ||
                      (r_state == ST_DQ_RD && r_head == r_tail);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_READ) n_state = ST_RD_WAIT;
                    else if (i_frame_last)   n_state = ST_CLEAR;
                end
            end
            ST_RD_WAIT: n_state = ST_IDLE;
            ST_CLEAR:   if (&r_clr) n_state = ST_SC_RD;
            ST_SC_RD:   n_state = ST_SC_CHK;
            ST_SC_CHK: begin
                if (hit)           n_state = ST_DQ_RD;
                else if (scan_end) n_state = ST_PAIR;
                else               n_state = ST_SC_RD;
            end
            ST_DQ_RD: begin
                if (r_head != r_tail) n_state = ST_DQ_WAIT;
                else if (scan_end)    n_state = ST_PAIR;
                else                  n_state = ST_SC_RD;
            end
            ST_DQ_WAIT: n_state = ST_NB_RD;
            ST_NB_RD: begin
                if (nb_ok)       n_state = ST_NB_CHK;
                else if (nb_end) n_state = ST_DQ_RD;
            end
            ST_NB_CHK:  n_state = nb_end ? ST_DQ_RD : ST_NB_RD;
            ST_PAIR:    if (pair_res.done) n_state = ST_SUM;
            ST_SUM:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE) || r_settle || o_out_valid;
        dark_we     = in_acc && (i_opcode == OP_LOAD) && (r_lp < r_n);
        dark_wdata  = (i_pixel_value < r_thresh);
        label_we    = 1'b0;
        label_waddr = r_p;
        label_wdata = lab_new;
        q_we        = 1'b0;
        q_wdata     = {r_p, r_sr, r_sc};
        unique case (r_state)
            ST_SC_RD: rd_addr = r_p;
            ST_NB_RD: rd_addr = nb_addr;
            default:  rd_addr = rp_eff[AW-1:0];
        endcase
        unique case (r_state)
            ST_CLEAR: begin
                label_we    = 1'b1;
                label_waddr = r_clr;
                label_wdata = '0;
            end
            ST_SC_CHK: begin
                label_we = hit;
                q_we     = hit;
            end
            ST_NB_CHK: begin
                label_we    = hit;
                label_waddr = nb_addr;
                label_wdata = r_lab;
                q_we        = hit;
                q_wdata     = {nb_addr, nb_r, nb_c};
            end
            default: ;
        endcase
    end

    assign rd_lab = r_labeled ? label_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thresh    <= THRESH_RST;
            r_rows      <= SIZE_RST;
            r_cols      <= SIZE_RST;
            r_settle    <= 1'b1;
            r_lp        <= '0;
            r_rp        <= '0;
            r_labeled   <= 1'b0;
            r_count     <= '0;
            r_far_a     <= '0;
            r_far_b     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= NW'(eff_rows) * NW'(eff_cols);
            r_settle <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                    CFG_ROWS:   r_rows   <= i_cfg_data;
                    CFG_COLS:   r_cols   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_opcode == OP_READ) begin
                        r_rd_last <= (rp_eff == r_n - NW'(1));
                        r_rp      <= (rp_eff + NW'(1) >= r_n) ? '0 : rp_eff + NW'(1);
                    end else if (in_acc) begin
                        if (i_frame_last) begin
                            r_lp  <= '0;
                            r_rp  <= '0;
                            r_clr <= '0;
                        end else if (dark_we) begin
                            r_lp <= r_lp + NW'(1);
                        end
                    end
                end
                ST_RD_WAIT: begin
                    o_out_valid      <= 1'b1;
                    o_result_kind    <= KIND_LABEL;
                    o_blob_label     <= rd_lab;
                    o_in_far_pair    <= (rd_lab != '0) &&
                                        (rd_lab == LABEL_W'(r_far_a) ||
                                         rd_lab == LABEL_W'(r_far_b));
                    o_blob_total     <= '0;
                    o_pair_first     <= '0;
                    o_pair_second    <= '0;
                    o_label_overflow <= 1'b0;
                    o_read_last      <= r_rd_last;
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (&r_clr) begin
                        r_p     <= '0;
                        r_sr    <= '0;
                        r_sc    <= '0;
                        r_count <= '0;
                        r_head  <= '0;
                        r_tail  <= '0;
                    end
                end
                ST_SC_CHK: begin
                    if (hit) begin
                        if (r_count < CNTW'(SEED_SLOTS)) begin
                            r_seed[r_count[SIW-1:0]] <= {r_sr, r_sc};
                        end
                        if (r_count != CNTW'(256)) r_count <= r_count + CNTW'(1);
                        r_lab  <= lab_new;
                        // seed goes in at the current tail; the queue never wraps in a frame
                        r_head <= r_tail;
                        r_tail <= r_tail + NW'(1);
                    end
                end
                ST_DQ_RD: begin
                    if (r_head != r_tail) r_head <= r_head + NW'(1);
                end
                ST_DQ_WAIT: begin
                    {r_q, r_qr, r_qc} <= q_rdata;
                    r_nr <= '0;
                    r_nc <= '0;
                end
                ST_NB_CHK: begin
                    if (hit) r_tail <= r_tail + NW'(1);
                end
                ST_SUM: begin
                    r_labeled        <= 1'b1;
                    o_out_valid      <= 1'b1;
                    o_result_kind    <= KIND_SUMMARY;
                    o_blob_label     <= '0;
                    o_in_far_pair    <= 1'b0;
                    o_blob_total     <= r_count[CNTW-1] ? LABEL_W'(255) : r_count[LABEL_W-1:0];
                    o_pair_first     <= r_far_a[OUT_PAIR_W-1:0];
                    o_pair_second    <= r_far_b[OUT_PAIR_W-1:0];
                    o_label_overflow <= r_count[CNTW-1];
                    o_read_last      <= 1'b0;
                end
                default: ;
            endcase

            if (r_state == ST_PAIR && pair_res.done) begin
                r_far_a <= pair_res.first;
                r_far_b <= pair_res.second;
            end
            if (adv_scan) begin
                r_p <= r_p + AW'(1);
                if (r_sc == last_col) begin
                    r_sc <= '0;
                    r_sr <= r_sr + RW'(1);
                end else begin
                    r_sc <= r_sc + CW'(1);
                end
            end
            if (nb_step) begin
                if (r_nc == 2'd2) begin
                    r_nc <= '0;
                    r_nr <= r_nr + 2'd1;
                end else begin
                    r_nc <= r_nc + 2'd1;
                end
            end
        end
    end

    blf_ram #(.WIDTH(1), .DEPTH(NPIX)) u_dark (
        .i_clk   (i_clk),
        .i_we    (dark_we),
        .i_waddr (r_lp[AW-1:0]),
        .i_wdata (dark_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dark_q)
    );

    blf_ram #(.WIDTH(LABEL_W), .DEPTH(NPIX)) u_label (
        .i_clk   (i_clk),
        .i_we    (label_we),
        .i_waddr (label_waddr),
        .i_wdata (label_wdata),
        .i_raddr (rd_addr),
        .o_rdata (label_q)
    );

    blf_ram #(.WIDTH(QW), .DEPTH(NPIX)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail[AW-1:0]),
        .i_wdata (q_wdata),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (q_rdata)
    );

    blf_pair #(.SEED_SLOTS(SEED_SLOTS), .RW(RW), .CW(CW)) u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_PAIR),
        .i_kk    (kk),
        .i_seeds (r_seed),
        .o_res   (pair_res)
    );

    // queue never runs ahead of what was enqueued
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("flood queue head passed tail");

    // a labeled pixel always gets a nonzero label during the fill
    a_label_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (label_we && r_state != ST_CLEAR) |-> (label_wdata != '0))
        else $error("zero label written during fill");

    // summary state always presents a word next cycle
    a_sum_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |=> (o_out_valid && o_result_kind == KIND_SUMMARY))
        else $error("summary word missing");

endmodule

/* verif/tb_blob_label_farthest_pair_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blob_label_farthest_pair_top
// Self-checking bench for the blob labeling / farthest pair block.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a clocked driver; a clocked monitor runs a
// behavioral model of the labeler on every accepted word and checks every
// result word against the oldest expectation. Frames go from directed
// corner cases to random frames with noise reads, early and late frame
// ends, clamped sizes and a label overflow frame, under several idle and
// stall mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_blob_label_farthest_pair_top;
    import blf_pkg::*;

    localparam int NPIX      = 65536;
    localparam int WDOG_MAX  = 300000;
    localparam int HOLD_LEN  = 300;

    typedef struct {
        t_opcode    op;
        logic [7:0] pix;
        logic       last;
    } t_word;

    typedef struct {
        t_kind      kind;
        logic [7:0] label;
        logic       far;
        logic [7:0] total;
        logic [2:0] pfirst;
        logic [2:0] psecond;
        logic       ovf;
        logic       rlast;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_opcode = 1'b0;
    logic [7:0]          i_pixel_value = '0;
    logic                i_frame_last = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_result_kind;
    logic [7:0]          o_blob_label;
    logic                o_in_far_pair;
    logic [7:0]          o_blob_total;
    logic [2:0]          o_pair_first;
    logic [2:0]          o_pair_second;
    logic                o_label_overflow;
    logic                o_read_last;

    blob_label_farthest_pair_top uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // pending input words and expected result words
    t_word   pend_words[$];
    t_result want_results[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic in_took = 1'b0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    // labeler model state
    int         lm_thr = 20, lm_rows = 256, lm_cols = 256;
    bit         lm_dark[NPIX];
    bit [7:0]   lm_label[NPIX];
    bit         lm_seen[NPIX];
    int         lm_fifo[NPIX];
    int         lm_seed[4];
    int         lm_lp = 0, lm_rp = 0;
    int         lm_total = 0, lm_pa = 0, lm_pb = 0;
    bit         lm_ovf = 0;

    // stimulus-side view: frame size and how far the dark map was ever written
    int g_n = 65536, g_hi = 0;

    function automatic int clamp_dim(int v);
        if (v == 0) return 1;
        return (v > 256) ? 256 : v;
    endfunction

    // breadth first flood fill over the whole frame, then the farthest seed pair
    function automatic void flood_label();
        int cols, n, cnt, head, tail, q, r, c, rr, cc, idx, kk, best, d, dr, dc;
        logic [7:0] lab;
        bit found;
        cols = clamp_dim(lm_cols);
        n = clamp_dim(lm_rows) * cols;
        cnt = 0;
        for (int i = 0; i < NPIX; i++) begin
            lm_seen[i] = 0;
            lm_label[i] = '0;
        end
        for (int p = 0; p < n; p++) begin
            if (!lm_dark[p] || lm_seen[p]) continue;
            cnt++;
            lab = (cnt > 255) ? 8'd255 : cnt[7:0];
            if (cnt <= 4) lm_seed[cnt-1] = p;
            lm_seen[p] = 1;
            lm_label[p] = lab;
            head = 0;
            tail = 0;
            lm_fifo[tail++] = p;
            while (head < tail) begin
                q = lm_fifo[head++];
                r = q / cols;
                c = q % cols;
                for (int a = -1; a <= 1; a++) begin
                    for (int b = -1; b <= 1; b++) begin
                        rr = r + a;
                        cc = c + b;
                        if (rr < 0 || cc < 0 || cc >= cols) continue;
                        idx = rr * cols + cc;
                        if (idx >= n || lm_seen[idx] || !lm_dark[idx]) continue;
                        lm_seen[idx] = 1;
                        lm_label[idx] = lab;
                        lm_fifo[tail++] = idx;
                    end
                end
            end
        end
        lm_total = (cnt > 255) ? 255 : cnt;
        lm_ovf = (cnt > 255);
        lm_pa = 0;
        lm_pb = 0;
        kk = (cnt < 4) ? cnt : 4;
        best = 0;
        found = 0;
        for (int i = 0; i < kk; i++) begin
            for (int j = i + 1; j < kk; j++) begin
                dr = lm_seed[i] / cols - lm_seed[j] / cols;
                dc = lm_seed[i] % cols - lm_seed[j] % cols;
                d = dr * dr + dc * dc;
                if (!found || d > best) begin
                    found = 1;
                    best = d;
                    lm_pa = i + 1;
                    lm_pb = j + 1;
                end
            end
        end
    endfunction

    function automatic void model_word(t_word w);
        t_result res;
        int n;
        logic [7:0] lab;
        n = clamp_dim(lm_rows) * clamp_dim(lm_cols);
        res = '{KIND_SUMMARY, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0};
        if (w.op == OP_LOAD) begin
            if (lm_lp < n) begin
                lm_dark[lm_lp] = (w.pix < lm_thr);
                lm_lp++;
            end
            if (!w.last) return;
            flood_label();
            lm_lp = 0;
            lm_rp = 0;
            res.total = lm_total[7:0];
            res.pfirst = lm_pa[2:0];
            res.psecond = lm_pb[2:0];
            res.ovf = lm_ovf;
        end else begin
            if (lm_rp >= n) lm_rp = 0;
            lab = lm_label[lm_rp];
            res.kind = KIND_LABEL;
            res.label = lab;
            res.far = (lab != 0) && (lab == lm_pa || lab == lm_pb);
            res.rlast = (lm_rp == n - 1);
            lm_rp = (lm_rp + 1 >= n) ? 0 : lm_rp + 1;
        end
        want_results = {want_results, res};
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // word driver: changes only on the falling edge
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (pend_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                w = pend_words.pop_front();
                i_in_valid <= 1'b1;
                i_opcode <= w.op;
                i_pixel_value <= w.pix;
                i_frame_last <= w.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // monitor: model accepted words, check result words, watchdog
    always @(posedge i_clk) begin
        t_result exp_r;
        t_word w;
        bit moved;
        moved = 0;
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                w.op = t_opcode'(i_opcode);
                w.pix = i_pixel_value;
                w.last = i_frame_last;
                model_word(w);
                moved = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1;
                if (want_results.size() == 0) begin
                    $display("%0t: unexpected result word kind %0d", $realtime, o_result_kind);
                    mismatches++;
                end else begin
                    exp_r = want_results.pop_front();
                    check_field("result_kind", exp_r.kind, o_result_kind);
                    check_field("blob_label", exp_r.label, o_blob_label);
                    check_field("in_far_pair", exp_r.far, o_in_far_pair);
                    check_field("blob_total", exp_r.total, o_blob_total);
                    check_field("pair_first", exp_r.pfirst, o_pair_first);
                    check_field("pair_second", exp_r.psecond, o_pair_second);
                    check_field("label_overflow", exp_r.ovf, o_label_overflow);
                    check_field("read_last", exp_r.rlast, o_read_last);
                end
            end
            if (moved || i_cfg_we) quiet_cycles <= 0;
            else if (quiet_cycles >= WDOG_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_reg(t_cfg_idx idx, int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        case (idx)
            CFG_THRESH: lm_thr = val & 8'hFF;
            CFG_ROWS:   lm_rows = val & 9'h1FF;
            default:    lm_cols = val & 9'h1FF;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_frame(int thr, int rows, int cols);
        write_reg(CFG_THRESH, thr);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        g_n = clamp_dim(rows & 9'h1FF) * clamp_dim(cols & 9'h1FF);
    endtask

    task automatic set_mix(int m);
        case (m)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    function automatic logic [7:0] pick_pixel(bit dark);
        if (lm_thr == 0) return 8'($urandom_range(0, 255));
        if (dark) return 8'($urandom_range(0, lm_thr - 1));
        return 8'($urandom_range(lm_thr, 255));
    endfunction

    function automatic void push_read();
        t_word w;
        w.op = OP_READ;
        w.pix = 8'($urandom_range(0, 255));
        w.last = 1'($urandom_range(0, 1));
        pend_words = {pend_words, w};
    endfunction

    function automatic void push_load(logic [7:0] pix, bit last);
        t_word w;
        w.op = OP_LOAD;
        w.pix = pix;
        w.last = last;
        pend_words = {pend_words, w};
    endfunction

    // grid: isolated dark pixels on even rows and even columns
    task automatic queue_frame(bit grid, int extra, bit early, int nreads);
        int cols, len;
        bit dark;
        cols = clamp_dim(lm_cols);
        len = g_n + extra;
        // an early end only where every pixel of the frame was written before
        if (early && g_hi >= g_n && g_n > 1) len = $urandom_range(1, g_n - 1);
        for (int k = 0; k < len; k++) begin
            if (!grid && $urandom_range(0, 99) < 4) push_read();
            if (grid) dark = ((k / cols) % 2 == 0) && ((k % cols) % 2 == 0);
            else dark = ($urandom_range(0, 99) < 45);
            push_load(pick_pixel(dark), k == len - 1);
            if (k < g_n && k + 1 > g_hi) g_hi = k + 1;
        end
        for (int k = 0; k < nreads; k++) push_read();
    endtask

    task automatic drain();
        while (pend_words.size() > 0 || i_in_valid || want_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] corners[9];
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: read before any labeling, then a 3x3 frame with four
        // isolated corners so the two diagonal pairs tie and the first one wins
        set_frame(20, 3, 3);
        push_read();
        corners = '{8'd0, 8'd20, 8'd19, 8'd255, 8'd128, 8'd200, 8'd5, 8'd20, 8'd0};
        for (int k = 0; k < 9; k++) push_load(corners[k], k == 8);
        g_hi = 9;
        for (int k = 0; k < 10; k++) push_read();
        drain();

        // random frames; sizes cover zero, one and clamped values
        for (int f = 0; f < 10; f++) begin
            set_mix(f % 4);
            case (f)
                0: begin set_frame(255, 1, 1);   queue_frame(0, 0, 0, 3);   end
                1: begin set_frame(0, 2, 2);     queue_frame(0, 2, 0, 6);   end
                2: begin set_frame(128, 0, 5);   queue_frame(0, 0, 0, 7);   end
                3: begin set_frame(100, 4, 6);   queue_frame(0, 0, 0, 30);  end
                4: begin
                    set_frame(60, 511, 1);
                    queue_frame(0, 0, 0, 80);
                    // receiver holds off once the readout is under way
                    while (pend_words.size() > 70) @(posedge i_clk);
                    hold_req++;
                end
                5: begin set_frame(200, 9, 0);   queue_frame(0, 0, 0, 40);  end
                6: begin set_frame(20, 3, 511);  queue_frame(1, 0, 0, 40);  end
                7: begin set_frame(150, 5, 5);   queue_frame(0, 0, 1, 30);  end
                8: begin set_frame(90, 6, 7);    queue_frame(0, 5, 0, 50);  end
                default: begin set_frame(255, 2, 8); queue_frame(0, 0, 0, 20); end
            endcase
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && want_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/core/blf_pkg.sv
rtl/core/blf_ram.sv
rtl/core/blf_pair.sv
rtl/core/blob_label_farthest_pair_top.sv
verif/tb_blob_label_farthest_pair_top.sv
